// File: rtl/assert_macros.svh
// Assertion macros for the port checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on the rising clock edge while reset is released.
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Checks that one condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/x86re_pkg.sv
package x86re_pkg;

    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int REG_NUM_W = 3;
    localparam int SEL_W     = (IDX_W > REG_NUM_W) ? IDX_W : REG_NUM_W;
    localparam int DATA_W    = 16;
    localparam int BYTE_W    = 8;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_MOVE  = 2'd2;
    localparam logic [1:0] OP_ADDR  = 2'd3;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_DISP8 = 2'd1;
    localparam logic [1:0] MODE_DISP16 = 2'd2;
    localparam logic [1:0] MODE_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic                 width16;
        logic [REG_NUM_W-1:0] reg_a;
        logic                 reg_a_high;
        logic [REG_NUM_W-1:0] reg_b;
        logic                 reg_b_high;
        logic [DATA_W-1:0]    value;
        logic [1:0]           mode;
        logic                 direct;
        logic                 disp_signed;
        logic                 use_a;
        logic                 use_b;
    } item_t;

    typedef struct packed {
        logic                 en;
        logic [REG_NUM_W-1:0] num;
        logic [DATA_W-1:0]    data;
    } wr_t;

    function automatic logic reg_in_range(input logic [REG_NUM_W-1:0] num);
        return 32'(num) < NUM_REGS;
    endfunction

    function automatic logic [IDX_W-1:0] reg_idx(input logic [REG_NUM_W-1:0] num);
        logic [SEL_W-1:0] wide;
        wide = SEL_W'(num);
        return wide[IDX_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] get_lane(input logic [DATA_W-1:0] word,
                                                   input logic whole, input logic high);
        logic [DATA_W-1:0] lane;
        if (whole)
            lane = word;
        else if (high)
            lane = {{(DATA_W-BYTE_W){1'b0}}, word[DATA_W-1:BYTE_W]};
        else
            lane = {{(DATA_W-BYTE_W){1'b0}}, word[BYTE_W-1:0]};
        return lane;
    endfunction

    function automatic logic [DATA_W-1:0] put_lane(input logic [DATA_W-1:0] word,
                                                   input logic whole, input logic high,
                                                   input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] merged;
        if (whole)
            merged = val;
        else if (high)
            merged = {val[BYTE_W-1:0], word[BYTE_W-1:0]};
        else
            merged = {word[DATA_W-1:BYTE_W], val[BYTE_W-1:0]};
        return merged;
    endfunction

endpackage

// File: rtl/x86re_rf.sv
module x86re_rf (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [x86re_pkg::REG_NUM_W-1:0]   rd_a_num,
    input  logic [x86re_pkg::REG_NUM_W-1:0]   rd_b_num,
    input  x86re_pkg::wr_t                    wr,
    output logic [x86re_pkg::DATA_W-1:0]      rd_a_data,
    output logic [x86re_pkg::DATA_W-1:0]      rd_b_data
);
    import x86re_pkg::*;

    logic [DATA_W-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;
    logic rd_a_ok_reg;
    logic rd_b_ok_reg;
    logic wr_ok;
    logic hit_a;
    logic hit_b;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;

    assign wr_ok  = wr.en && reg_in_range(wr.num);
    assign wr_idx = reg_idx(wr.num);
    assign a_idx  = reg_idx(rd_a_num);
    assign b_idx  = reg_idx(rd_b_num);
    assign hit_a  = wr_ok && (wr.num == rd_a_num);
    assign hit_b  = wr_ok && (wr.num == rd_b_num);

    // A write in the same cycle as a read of the same register is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_a_reg <= hit_a ? wr.data : mem[a_idx];
            rd_b_reg <= hit_b ? wr.data : mem[b_idx];
        end
    end

    // Entries never written since reset read as zero, as do numbers past the file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_a_ok_reg <= 1'b0;
            rd_b_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_a_ok_reg <= reg_in_range(rd_a_num) && (hit_a || vld_reg[a_idx]);
                rd_b_ok_reg <= reg_in_range(rd_b_num) && (hit_b || vld_reg[b_idx]);
            end
        end
    end

    assign rd_a_data = rd_a_ok_reg ? rd_a_reg : '0;
    assign rd_b_data = rd_b_ok_reg ? rd_b_reg : '0;

endmodule

// File: rtl/x86re_exec.sv
module x86re_exec (
    input  x86re_pkg::item_t                item,
    input  logic [x86re_pkg::DATA_W-1:0]    rd_a_data,
    input  logic [x86re_pkg::DATA_W-1:0]    rd_b_data,
    output x86re_pkg::wr_t                  wr_req,
    output logic [x86re_pkg::DATA_W-1:0]    result,
    output logic                            fault
);
    import x86re_pkg::*;

    logic [DATA_W-1:0] lane_a;
    logic [DATA_W-1:0] lane_b;
    logic [DATA_W-1:0] disp;
    logic [DATA_W-1:0] term_a;
    logic [DATA_W-1:0] term_b;

    assign lane_a = get_lane(rd_a_data, item.width16, item.reg_a_high);
    assign lane_b = get_lane(rd_b_data, item.width16, item.reg_b_high);
    assign term_a = item.use_a ? lane_a : '0;
    assign term_b = item.use_b ? lane_b : '0;

    always_comb
    begin
        case (item.mode)
            MODE_NONE:   disp = item.direct ? item.value : '0;
            MODE_DISP8:  disp = {{(DATA_W-BYTE_W){item.disp_signed && item.value[BYTE_W-1]}},
                                 item.value[BYTE_W-1:0]};
            MODE_DISP16: disp = item.value;
            default:     disp = '0;
        endcase
    end

    always_comb
    begin
        wr_req.en   = 1'b0;
        wr_req.num  = item.reg_a;
        wr_req.data = put_lane(rd_a_data, item.width16, item.reg_a_high, item.value);
        result      = '0;
        fault       = 1'b0;
        case (item.op)
            OP_READ:
            begin
                result = lane_a;
            end
            OP_WRITE:
            begin
                wr_req.en = 1'b1;
            end
            OP_MOVE:
            begin
                wr_req.en   = 1'b1;
                wr_req.data = put_lane(rd_a_data, item.width16, item.reg_a_high, lane_b);
            end
            OP_ADDR:
            begin
                if (item.mode == MODE_BAD)
                    fault = 1'b1;
                else
                    result = disp + term_a + term_b;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

// File: rtl/x86_16_register_file_and_ea_top.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | op, width16, reg_a, reg_a_high, reg_b, reg_b_high,
//         |                      | value, mode, direct, disp_signed, use_a, use_b
// output  | out_valid / out_ready| result, fault
//
// One transfer per cycle is sustained unless the output stalls; the result is registered.
// The register file is read when a transfer is taken and written when the item
// moves into the result register, so a write is seen by the very next item.
// Reset clears all eight registers to zero through per-entry valid bits.
// A stalled result register holds the item in the input stage, which then stalls input.
module x86_16_register_file_and_ea_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic                              width16,
    input  logic [x86re_pkg::REG_NUM_W-1:0]   reg_a,
    input  logic                              reg_a_high,
    input  logic [x86re_pkg::REG_NUM_W-1:0]   reg_b,
    input  logic                              reg_b_high,
    input  logic [x86re_pkg::DATA_W-1:0]      value,
    input  logic [1:0]                        mode,
    input  logic                              direct,
    input  logic                              disp_signed,
    input  logic                              use_a,
    input  logic                              use_b,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [x86re_pkg::DATA_W-1:0]      result,
    output logic                              fault
);
    import x86re_pkg::*;

    item_t stg_reg;
    logic stg_vld_reg;
    logic out_vld_reg;
    logic [DATA_W-1:0] result_reg;
    logic fault_reg;
    logic advance;
    logic in_xfer;
    logic [DATA_W-1:0] rd_a_data;
    logic [DATA_W-1:0] rd_b_data;
    wr_t wr_req;
    wr_t wr;
    logic [DATA_W-1:0] result_next;
    logic fault_next;

    assign advance  = stg_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !stg_vld_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stg_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stg_reg <= '{op: op, width16: width16, reg_a: reg_a, reg_a_high: reg_a_high,
                         reg_b: reg_b, reg_b_high: reg_b_high, value: value, mode: mode,
                         direct: direct, disp_signed: disp_signed, use_a: use_a,
                         use_b: use_b};
        end
        if (advance)
        begin
            result_reg <= result_next;
            fault_reg  <= fault_next;
        end
    end

    x86re_rf u_rf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .rd_a_num  (reg_a),
        .rd_b_num  (reg_b),
        .wr        (wr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    x86re_exec u_exec (
        .item      (stg_reg),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .wr_req    (wr_req),
        .result    (result_next),
        .fault     (fault_next)
    );

    assign wr = '{en: wr_req.en && advance, num: wr_req.num, data: wr_req.data};

    assign out_valid = out_vld_reg;
    assign result    = result_reg;
    assign fault     = fault_reg;

endmodule

// File: rtl/x86re_checker.sv
`include "assert_macros.svh"

module x86re_port_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [x86re_pkg::DATA_W-1:0]      result,
    input logic                              fault
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(result) && $stable(fault), "stalled result changed")

    `ASSERT_AT(a_fault_zero, clk, rst_n, (out_valid && fault) |-> (result == '0),
        "fault result is not zero")

    `ASSERT_AT(a_in_stall, clk, rst_n, !in_ready |-> (out_valid && !out_ready),
        "input stalled without an output stall")

    `ASSERT_AT(a_out_source, clk, rst_n,
        $rose(out_valid) |-> ($past(in_valid, 2) && $past(in_ready, 2)),
        "result appeared without an input transfer two cycles earlier")

endmodule

bind x86_16_register_file_and_ea_top x86re_port_checker u_chk (.*);

// File: test/x86re_checker.sv
module x86re_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic                              width16,
    input  logic [x86re_pkg::REG_NUM_W-1:0]   reg_a,
    input  logic                              reg_a_high,
    input  logic [x86re_pkg::REG_NUM_W-1:0]   reg_b,
    input  logic                              reg_b_high,
    input  logic [x86re_pkg::DATA_W-1:0]      value,
    input  logic [1:0]                        mode,
    input  logic                              direct,
    input  logic                              disp_signed,
    input  logic                              use_a,
    input  logic                              use_b,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [x86re_pkg::DATA_W-1:0]      result,
    input  logic                              fault,
    output int                                fail_count,
    output int                                outstanding
);
    import x86re_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              fault;
    } outcome_t;

    logic [DATA_W-1:0] gpr [NUM_REGS];
    outcome_t          expected_outcomes [$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    initial
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            gpr[i] = '0;
        end
    end

    function automatic logic [DATA_W-1:0] fetch_lane(input logic [REG_NUM_W-1:0] num,
                                                     input logic whole, input logic high);
        logic [DATA_W-1:0] word;
        if (32'(num) >= NUM_REGS)
            return '0;
        word = gpr[num];
        if (whole)
            return word;
        if (high)
            return {8'h00, word[15:8]};
        return {8'h00, word[7:0]};
    endfunction

    function automatic void store_lane(input logic [REG_NUM_W-1:0] num, input logic whole,
                                       input logic high, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] word;
        if (32'(num) >= NUM_REGS)
            return;
        word = gpr[num];
        if (whole)
            word = data;
        else if (high)
            word = {data[7:0], word[7:0]};
        else
            word = {word[15:8], data[7:0]};
        gpr[num] = word;
    endfunction

    // Applies one operation to the register copy and returns its result.
    function automatic outcome_t execute_op(input item_t it);
        outcome_t          o;
        logic [DATA_W-1:0] disp;
        o.result = '0;
        o.fault  = 1'b0;
        disp     = '0;
        case (it.op)
            OP_READ:
                o.result = fetch_lane(it.reg_a, it.width16, it.reg_a_high);
            OP_WRITE:
                store_lane(it.reg_a, it.width16, it.reg_a_high, it.value);
            OP_MOVE:
                store_lane(it.reg_a, it.width16, it.reg_a_high,
                           fetch_lane(it.reg_b, it.width16, it.reg_b_high));
            default:
            begin
                if (it.mode == MODE_BAD)
                begin
                    o.fault = 1'b1;
                end
                else
                begin
                    if (it.mode == MODE_NONE)
                        disp = it.direct ? it.value : '0;
                    else if (it.mode == MODE_DISP8)
                        disp = {(it.disp_signed && it.value[7]) ? 8'hff : 8'h00,
                                it.value[7:0]};
                    else
                        disp = it.value;
                    if (it.use_a)
                        disp = disp + fetch_lane(it.reg_a, it.width16, it.reg_a_high);
                    if (it.use_b)
                        disp = disp + fetch_lane(it.reg_b, it.width16, it.reg_b_high);
                    o.result = disp;
                end
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        item_t    it;
        outcome_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    report_mismatch("unexpected transfer", result, '0);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (result !== want.result)
                        report_mismatch("result", result, want.result);
                    if (fault !== want.fault)
                        report_mismatch("fault", DATA_W'(fault), DATA_W'(want.fault));
                end
            end
            if (in_valid && in_ready)
            begin
                it = '{op: op, width16: width16, reg_a: reg_a, reg_a_high: reg_a_high,
                       reg_b: reg_b, reg_b_high: reg_b_high, value: value, mode: mode,
                       direct: direct, disp_signed: disp_signed, use_a: use_a,
                       use_b: use_b};
                expected_outcomes.push_back(execute_op(it));
            end
            outstanding <= expected_outcomes.size();
        end
    end

endmodule

// File: test/testbench.sv
module testbench;
    import x86re_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1400;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           op;
    logic                 width16;
    logic [REG_NUM_W-1:0] reg_a;
    logic                 reg_a_high;
    logic [REG_NUM_W-1:0] reg_b;
    logic                 reg_b_high;
    logic [DATA_W-1:0]    value;
    logic [1:0]           mode;
    logic                 direct;
    logic                 disp_signed;
    logic                 use_a;
    logic                 use_b;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DATA_W-1:0]    result;
    logic                 fault;
    int                   fail_count;
    int                   outstanding;
    int                   cycles = 0;
    bit                   steady = 1'b0;

    x86_16_register_file_and_ea_top DUT (.*);

    x86re_checker checker_inst (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic item_t make_item(input int o, input int w, input int ra, input int rah,
                                        input int rb, input int rbh, input int v,
                                        input int md, input int dir, input int sg,
                                        input int ua, input int ub);
        item_t it;
        it.op          = 2'(o);
        it.width16     = 1'(w);
        it.reg_a       = REG_NUM_W'(ra);
        it.reg_a_high  = 1'(rah);
        it.reg_b       = REG_NUM_W'(rb);
        it.reg_b_high  = 1'(rbh);
        it.value       = DATA_W'(v);
        it.mode        = 2'(md);
        it.direct      = 1'(dir);
        it.disp_signed = 1'(sg);
        it.use_a       = 1'(ua);
        it.use_b       = 1'(ub);
        return it;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= it.op;
        width16     <= it.width16;
        reg_a       <= it.reg_a;
        reg_a_high  <= it.reg_a_high;
        reg_b       <= it.reg_b;
        reg_b_high  <= it.reg_b_high;
        value       <= it.value;
        mode        <= it.mode;
        direct      <= it.direct;
        disp_signed <= it.disp_signed;
        use_a       <= it.use_a;
        use_b       <= it.use_b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        int          v;
        logic [15:0] data;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_READ;
        width16     = 1'b0;
        reg_a       = '0;
        reg_a_high  = 1'b0;
        reg_b       = '0;
        reg_b_high  = 1'b0;
        value       = '0;
        mode        = MODE_NONE;
        direct      = 1'b0;
        disp_signed = 1'b0;
        use_a       = 1'b0;
        use_b       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(OP_READ,  1, 0, 0, 0, 0, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_WRITE, 1, 0, 1, 0, 0, 16'hffff, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_READ,  0, 0, 1, 0, 0, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_READ,  0, 0, 0, 0, 0, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_WRITE, 0, 1, 1, 0, 0, 16'hff5a, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_WRITE, 0, 1, 0, 0, 0, 16'hff80, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_READ,  1, 1, 0, 0, 0, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_MOVE,  1, 2, 0, 0, 1, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_MOVE,  0, 3, 1, 1, 0, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_MOVE,  0, 3, 0, 1, 1, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_READ,  1, 3, 0, 0, 0, 16'hffff, MODE_BAD, 1, 1, 1, 1));
        send_item(make_item(OP_ADDR,  1, 0, 0, 2, 0, 16'hffff, MODE_NONE, 0, 1, 1, 1));
        send_item(make_item(OP_ADDR,  1, 0, 0, 0, 0, 16'h1234, MODE_NONE, 1, 0, 0, 0));
        send_item(make_item(OP_ADDR,  1, 1, 0, 0, 0, 16'h0080, MODE_DISP8, 0, 1, 1, 0));
        send_item(make_item(OP_ADDR,  1, 0, 0, 3, 0, 16'hffff, MODE_DISP8, 0, 0, 0, 1));
        send_item(make_item(OP_ADDR,  1, 1, 0, 0, 0, 16'hff7f, MODE_DISP8, 0, 1, 1, 0));
        send_item(make_item(OP_ADDR,  0, 0, 1, 3, 0, 16'hffff, MODE_DISP16, 0, 1, 1, 1));
        send_item(make_item(OP_ADDR,  0, 1, 1, 3, 1, 16'h8000, MODE_DISP16, 0, 0, 0, 0));
        send_item(make_item(OP_ADDR,  1, 0, 0, 2, 0, 16'h1234, MODE_BAD, 0, 0, 1, 1));
        send_item(make_item(OP_ADDR,  0, 7, 1, 7, 1, 16'hffff, MODE_BAD, 1, 1, 0, 0));
        send_item(make_item(OP_WRITE, 1, 7, 0, 0, 0, 16'h8001, MODE_BAD, 1, 1, 1, 1));
        send_item(make_item(OP_MOVE,  0, 7, 1, 7, 0, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_READ,  0, 7, 1, 0, 0, 16'h0000, MODE_NONE, 0, 0, 0, 0));
        send_item(make_item(OP_ADDR,  1, 7, 0, 7, 0, 16'h0000, MODE_NONE, 1, 1, 1, 1));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            v = $urandom_range(0, 7);
            case (v)
                0: data = 16'hffff;
                1: data = 16'h0000;
                2: data = 16'h0080;
                3: data = 16'h007f;
                4: data = 16'h8000;
                default: data = 16'($urandom);
            endcase
            send_item(make_item($urandom_range(0, 3), $urandom_range(0, 1),
                                $urandom_range(0, 7), $urandom_range(0, 1),
                                $urandom_range(0, 7), $urandom_range(0, 1), data,
                                $urandom_range(0, 3), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom_range(0, 1)));
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (12) @(posedge clk);

        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
